FILE: rtl/core/gg_pkg.sv
`default_nettype none
package gg_pkg;

  localparam int DATA_W     = 32;
  localparam int GRAD_W     = 48;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 16;
  localparam int COLS_REG_W = 11;
  localparam int ROWS_REG_W = 16;
  localparam int CFG_W      = 16;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_GRID_COLUMNS = 1'b0,
    CFG_GRID_ROWS    = 1'b1
  } cfg_index_t;

  // Request to a gradient divider: (minuend - subtrahend) / spacing, or / (2 * spacing) when twice is set
  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] minuend;
    logic signed [DATA_W-1:0] subtrahend;
    logic [DATA_W-1:0]        spacing;
    logic                     twice;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic signed [GRAD_W-1:0] quotient;
    logic                     zero;
  } div_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/gg_if.sv
`default_nettype none
interface gg_in_if;
  import gg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic [DATA_W-1:0]        row_spacing;
  logic [DATA_W-1:0]        column_spacing;
  modport source (output valid, sample, row_spacing, column_spacing, input ready);
  modport sink (input valid, sample, row_spacing, column_spacing, output ready);
endinterface

interface gg_out_if;
  import gg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [COL_W-1:0]         out_column;
  logic [ROW_W-1:0]         out_row;
  logic signed [GRAD_W-1:0] gradient_x;
  logic signed [GRAD_W-1:0] gradient_y;
  logic                     zero_spacing;
  logic                     last_of_run;
  modport source (output valid, out_column, out_row, gradient_x, gradient_y,
                  zero_spacing, last_of_run, input ready);
  modport sink (input valid, out_column, out_row, gradient_x, gradient_y,
                zero_spacing, last_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/grid_gradient_central_difference.sv
// Streaming 2-D gradient of a grid by central differences.
// in_ch carries one grid sample a transaction in raster order, with the x
// spacing of its row and the y spacing of its column. out_ch carries the
// gradient points, each tagged with column and row; last_of_run marks the
// final point caused by an input transaction. Points trail the input by one
// row and one column; on the last row the points of that row follow those
// of the row above. cfg_write/cfg_index/cfg_data set grid_columns and
// grid_rows; write them only while the block is idle (not enforced here).
// One transaction is handled at a time: line-store reads, up to four
// results (two 47-step bit-serial dividers work on x and y together), then
// the write-back. An input that causes no result goes straight from the
// reads to the write-back.
// Line stores are three single-port-read, single-port-write memories of
// MAX_COLUMNS entries; they are not cleared at reset, the grid simply
// starts again at column 0, row 0. While out_ch stalls the block holds the
// waiting result and does not accept new input until it has room.
`default_nettype none
module grid_gradient_central_difference
  import gg_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  gg_in_if.sink                 in_ch,
  gg_out_if.source              out_ch
);

  localparam int AW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_DIV, S_WAIT, S_EMIT, S_W0, S_W1, S_W2
  } state_t;

  state_t state;

  // Configuration
  logic [COLS_REG_W-1:0] grid_columns;
  logic [ROWS_REG_W-1:0] grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLS_REG_W'(1024);
      grid_rows    <= ROWS_REG_W'(2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GRID_COLUMNS: grid_columns <= cfg_data[COLS_REG_W-1:0];
        CFG_GRID_ROWS:    grid_rows    <= cfg_data[ROWS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size and place the incoming sample
  logic [AW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;
  logic [AW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [AW-1:0]    c_in;

  always_comb begin
    if (32'(grid_columns) < 32'd2) col_last = AW'(1);
    else if (32'(grid_columns) > 32'(MAX_COLUMNS)) col_last = AW'(MAX_COLUMNS - 1);
    else col_last = AW'(32'(grid_columns) - 32'd1);
    row_last = (grid_rows < ROW_W'(2)) ? ROW_W'(1) : grid_rows - 1'b1;
    c_in     = (col_cnt > col_last) ? col_last : col_cnt;
  end

  // Latched transaction
  logic [AW-1:0]            c_q;
  logic [ROW_W-1:0]         r_q;
  logic                     lc_q, lr_q;
  logic signed [DATA_W-1:0] v_q;
  logic [DATA_W-1:0]        c0_q;
  logic [DATA_W-1:0]        rs0, rs1;
  logic signed [DATA_W-1:0] rec0, rec1;

  // Values read from the line stores
  logic signed [DATA_W-1:0] p0, p1, p2, s0, s1;
  logic [DATA_W-1:0]        c1;

  // Memories
  logic signed [DATA_W-1:0] pv_mem [MAX_COLUMNS];
  logic signed [DATA_W-1:0] sp_mem [MAX_COLUMNS];
  logic [DATA_W-1:0]        cs_mem [MAX_COLUMNS];
  logic signed [DATA_W-1:0] pv_rd, sp_rd;
  logic [DATA_W-1:0]        cs_rd;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic                     line_we;
  logic signed [DATA_W-1:0] pv_wd, sp_wd;

  always_comb begin
    unique case (state)
      S_RD1:   rd_addr = c_q - 1'b1;
      S_RD2:   rd_addr = c_q - AW'(2);
      default: rd_addr = c_q;
    endcase
    line_we = 1'b0;
    wr_addr = c_q;
    pv_wd   = v_q;
    sp_wd   = p0;
    unique case (state)
      S_W0: begin
        line_we = (c_q >= AW'(2));
        wr_addr = c_q - AW'(2);
        pv_wd   = rec1;
        sp_wd   = p2;
      end
      S_W1: begin
        line_we = lc_q;
        wr_addr = c_q - 1'b1;
        pv_wd   = rec0;
        sp_wd   = p1;
      end
      S_W2: begin
        line_we = lc_q;
      end
      default: ;
    endcase
  end

  // Line stores: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (line_we) pv_mem[wr_addr] <= pv_wd;
    pv_rd <= pv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (line_we) sp_mem[wr_addr] <= sp_wd;
    sp_rd <= sp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_W0) cs_mem[c_q] <= c0_q;
    cs_rd <= cs_mem[c_q - 1'b1];
  end

  // Result selection
  logic [1:0]       idx;
  logic [3:0]       present;
  logic             top, c_one;
  logic             more;
  logic [1:0]       idx_next;
  div_req_t         dx_req, dy_req;
  div_res_t         dx_res, dy_res;
  logic [AW-1:0]    sel_col;
  logic [ROW_W-1:0] sel_row;

  always_comb begin
    top        = (r_q == ROW_W'(1));
    c_one      = (c_q == AW'(1));
    present[0] = (r_q != '0) && (c_q != '0);
    present[1] = present[0] && lc_q;
    present[2] = present[0] && lr_q;
    present[3] = present[2] && lc_q;
    more     = 1'b0;
    idx_next = idx;
    priority if (idx == 2'd0 && present[1]) begin
      more = 1'b1; idx_next = 2'd1;
    end else if ((idx == 2'd0 || idx == 2'd1) && present[2]) begin
      more = 1'b1; idx_next = 2'd2;
    end else if (idx == 2'd2 && present[3]) begin
      more = 1'b1; idx_next = 2'd3;
    end else begin
      more = 1'b0;
    end
    dx_req.start = (state == S_DIV);
    dy_req.start = (state == S_DIV);
    unique case (idx)
      2'd0: begin
        sel_col = c_q - 1'b1;   sel_row = r_q - 1'b1;
        dx_req.subtrahend = c_one ? p1 : p2; dx_req.minuend = p0;
        dx_req.twice = !c_one; dx_req.spacing = rs1;
        dy_req.subtrahend = top ? p1 : s1;   dy_req.minuend = rec0;
        dy_req.twice = !top;   dy_req.spacing = c1;
      end
      2'd1: begin
        sel_col = c_q;          sel_row = r_q - 1'b1;
        dx_req.subtrahend = p1; dx_req.minuend = p0;
        dx_req.twice = 1'b0;    dx_req.spacing = rs1;
        dy_req.subtrahend = top ? p0 : s0;   dy_req.minuend = v_q;
        dy_req.twice = !top;    dy_req.spacing = c0_q;
      end
      2'd2: begin
        sel_col = c_q - 1'b1;   sel_row = r_q;
        dx_req.subtrahend = c_one ? rec0 : rec1; dx_req.minuend = v_q;
        dx_req.twice = !c_one;  dx_req.spacing = rs0;
        dy_req.subtrahend = p1; dy_req.minuend = rec0;
        dy_req.twice = 1'b0;    dy_req.spacing = c1;
      end
      default: begin
        sel_col = c_q;          sel_row = r_q;
        dx_req.subtrahend = rec0; dx_req.minuend = v_q;
        dx_req.twice = 1'b0;    dx_req.spacing = rs0;
        dy_req.subtrahend = p0; dy_req.minuend = v_q;
        dy_req.twice = 1'b0;    dy_req.spacing = c0_q;
      end
    endcase
  end

  gg_div u_div_x (.clk(clk), .rst(rst), .req(dx_req), .res(dx_res));
  gg_div u_div_y (.clk(clk), .rst(rst), .req(dy_req), .res(dy_res));

  assign in_ch.ready = (state == S_IDLE);

  logic out_free;
  assign out_free = !out_ch.valid || out_ch.ready;

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      col_cnt      <= '0;
      row_cnt      <= '0;
      rs1          <= '0;
      rec0         <= '0;
      rec1         <= '0;
      out_ch.valid <= 1'b0;
      idx          <= 2'd0;
    end else begin
      // Load a result when the register is free, drop it once taken
      if (state == S_EMIT && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            c_q   <= c_in;
            r_q   <= row_cnt;
            lc_q  <= (c_in >= col_last);
            lr_q  <= (row_cnt >= row_last);
            v_q   <= in_ch.sample;
            rs0   <= in_ch.row_spacing;
            c0_q  <= in_ch.column_spacing;
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          p0    <= pv_rd;
          s0    <= sp_rd;
          c1    <= cs_rd;
          state <= S_RD2;
        end
        S_RD2: begin
          p1    <= pv_rd;
          s1    <= sp_rd;
          state <= S_RD3;
        end
        S_RD3: begin
          p2    <= pv_rd;
          idx   <= 2'd0;
          state <= present[0] ? S_DIV : S_W0;
        end
        S_DIV:  state <= S_WAIT;
        S_WAIT: if (!dx_res.busy && !dy_res.busy) state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_ch.out_column   <= COL_W'(sel_col);
            out_ch.out_row      <= sel_row;
            out_ch.gradient_x   <= dx_res.quotient;
            out_ch.gradient_y   <= dy_res.quotient;
            out_ch.zero_spacing <= dx_res.zero || dy_res.zero;
            out_ch.last_of_run  <= !more;
            idx                 <= idx_next;
            state               <= more ? S_DIV : S_W0;
          end
        end
        S_W0: state <= S_W1;
        S_W1: state <= S_W2;
        S_W2: begin
          if (lc_q) begin
            rs1     <= rs0;
            col_cnt <= '0;
            row_cnt <= lr_q ? '0 : r_q + 1'b1;
          end else begin
            col_cnt <= c_q + 1'b1;
          end
          rec1  <= rec0;
          rec0  <= v_q;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Dividers rest whenever no transaction is in flight
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !dx_res.busy && !dy_res.busy)
    else $error("divider busy while idle");

  // An accepted transaction starts the line-store reads
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_RD0)
    else $error("accept did not start reads");

  // A row end returns the column counter to zero
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    state == S_W2 && lc_q |=> col_cnt == '0)
    else $error("column counter did not wrap");

  // A result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_ch.valid && !out_ch.ready |=> state == S_EMIT)
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/gg_div.sv
`default_nettype none
module gg_div
  import gg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_res_t      res
);

  localparam int MAG_W  = DATA_W + 1;
  localparam int INT_W  = GRAD_W - DATA_W - 1;
  localparam int STEPS  = GRAD_W - 1;
  localparam int CNT_W  = $clog2(STEPS + 1);

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag_in;
  logic [MAG_W-1:0]        d_in;
  logic                    sat_in;
  logic [MAG_W:0]          trial;
  logic                    ge;
  logic [MAG_W-1:0]        rem_next;
  logic [STEPS-1:0]        q_new;

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [MAG_W-1:0]        rem;
  logic [STEPS-1:0]        low;
  logic [STEPS-1:0]        q;
  logic                    neg;
  logic [MAG_W-1:0]        d;
  logic [GRAD_W-1:0]       quot;
  logic                    zero;

  // Operand set-up: magnitude, divisor and overflow test
  always_comb begin
    diff   = {req.minuend[DATA_W-1], req.minuend} -
             {req.subtrahend[DATA_W-1], req.subtrahend};
    mag_in = diff[MAG_W-1] ? MAG_W'(~diff + 1'b1) : MAG_W'(diff);
    d_in   = req.twice ? {req.spacing, 1'b0} : {1'b0, req.spacing};
    sat_in = {{INT_W{1'b0}}, mag_in} >= {d_in, {INT_W{1'b0}}};
  end

  // One restoring step
  always_comb begin
    trial    = {rem, low[STEPS-1]};
    ge       = trial >= {1'b0, d};
    rem_next = ge ? MAG_W'(trial - {1'b0, d}) : trial[MAG_W-1:0];
    q_new    = {q[STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      neg <= diff[MAG_W-1];
      d   <= d_in;
      if (d_in == '0) begin
        quot <= '0;
        zero <= 1'b1;
        busy <= 1'b0;
      end else if (sat_in) begin
        quot <= diff[MAG_W-1] ? {1'b1, {STEPS{1'b0}}} : {1'b0, {STEPS{1'b1}}};
        zero <= 1'b0;
        busy <= 1'b0;
      end else begin
        busy <= 1'b1;
        zero <= 1'b0;
        cnt  <= CNT_W'(STEPS);
        rem  <= mag_in >> INT_W;
        low  <= {mag_in[INT_W-1:0], {DATA_W{1'b0}}};
        q    <= '0;
      end
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[STEPS-2:0], 1'b0};
      q   <= q_new;
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        quot <= neg ? GRAD_W'(~{1'b0, q_new} + 1'b1) : {1'b0, q_new};
      end
    end
  end

  assign res.busy     = busy;
  assign res.quotient = quot;
  assign res.zero     = zero;

endmodule
`default_nettype wire
